// ----- design/multiset_equality_check_macros.svh -----
// Assertion macros shared by the checker of the multiset equality block.
`ifndef MULTISET_EQUALITY_CHECK_MACROS_SVH
`define MULTISET_EQUALITY_CHECK_MACROS_SVH

// Property checked only while the block is out of reset.
`define MEC_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mec_pkg.sv -----
// Package with the types and constants of the multiset equality block.
package mec_pkg;

    // Field widths of the streams and the default capacity.
    localparam int VALUE_W          = 32;
    localparam int IN_DATA_W        = 64;
    localparam int OUT_DATA_W       = 8;
    localparam int MAX_ELEMENTS_DEF = 64;

    // Controller states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_CLR,
        S_RDA,
        S_RDB,
        S_CMP,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic drop;
        logic clr_wr;
        logic rd_a;
        logic rd_b;
        logic claim;
        logic j_zero;
        logic j_inc;
        logic i_zero;
        logic i_inc;
        logic set_eq;
        logic set_ne;
        logic restart;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic j_last;
        logic i_last;
        logic hit;
    } t_sts;

endpackage

// ----- design/mec_ctrl.sv -----
// Controller state machine of the multiset equality block.
module mec_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tlast,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  mec_pkg::t_sts i_sts,
    output mec_pkg::t_cmd o_cmd
);
    import mec_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            S_LOAD: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.store = !i_sts.full;
                    o_cmd.drop  = i_sts.full;
                    if (s_axis_tlast) begin
                        o_cmd.j_zero = 1'b1;
                        n_state      = S_CLR;
                    end
                end
            end
            S_CLR: begin
                // Sweep the claimed flags of the stored entries to zero.
                o_cmd.clr_wr = 1'b1;
                o_cmd.j_inc  = 1'b1;
                if (i_sts.j_last) begin
                    o_cmd.j_zero = 1'b1;
                    o_cmd.i_zero = 1'b1;
                    n_state      = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.claim  = 1'b1;
                    o_cmd.i_inc  = 1'b1;
                    o_cmd.j_zero = 1'b1;
                    if (i_sts.i_last) begin
                        o_cmd.set_eq = 1'b1;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_RDA;
                    end
                end else if (i_sts.j_last) begin
                    o_cmd.set_ne = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_RDB;
                end
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ----- design/mec_datapath.sv -----
// Datapath of the multiset equality block: element stores, counters, compare.
module mec_datapath #(
    parameter int MAX_ELEMENTS = mec_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [mec_pkg::VALUE_W-1:0]    i_value_a,
    input  logic [mec_pkg::VALUE_W-1:0]    i_value_b,
    input  mec_pkg::t_cmd                  i_cmd,
    output mec_pkg::t_sts                  o_sts,
    output logic [mec_pkg::OUT_DATA_W-1:0] o_result
);
    import mec_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic [VALUE_W-1:0] mem_a [MAX_ELEMENTS];
    logic [VALUE_W-1:0] mem_b [MAX_ELEMENTS];
    logic               mem_c [MAX_ELEMENTS];

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ovf;
    logic               n_ovf;
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   n_i;
    logic [IDX_W-1:0]   r_j;
    logic [IDX_W-1:0]   n_j;
    logic               r_equal;
    logic [VALUE_W-1:0] r_rd_a;
    logic [VALUE_W-1:0] r_rd_b;
    logic               r_rd_c;

    // Counter updates.
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_i     = r_i;
        n_j     = r_j;
        if (i_cmd.store) begin
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.drop) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.restart) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
        if (i_cmd.i_zero) begin
            n_i = '0;
        end else if (i_cmd.i_inc) begin
            n_i = r_i + IDX_W'(1);
        end
        if (i_cmd.j_zero) begin
            n_j = '0;
        end else if (i_cmd.j_inc) begin
            n_j = r_j + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // Element stores, written during loading.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem_a[r_count[IDX_W-1:0]] <= i_value_a;
            mem_b[r_count[IDX_W-1:0]] <= i_value_b;
        end
        if (i_cmd.rd_a) begin
            r_rd_a <= mem_a[r_i];
        end
        if (i_cmd.rd_b) begin
            r_rd_b <= mem_b[r_j];
        end
    end

    // Claimed flags: cleared by a sweep, set when an element is matched.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.claim) begin
            mem_c[r_j] <= i_cmd.claim;
        end
        if (i_cmd.rd_b) begin
            r_rd_c <= mem_c[r_j];
        end
    end

    // Result flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_eq) begin
            r_equal <= 1'b1;
        end else if (i_cmd.set_ne) begin
            r_equal <= 1'b0;
        end
    end

    assign o_sts.full   = (r_count == CNT_W'(MAX_ELEMENTS));
    assign o_sts.j_last = ((CNT_W'(r_j) + CNT_W'(1)) == r_count);
    assign o_sts.i_last = ((CNT_W'(r_i) + CNT_W'(1)) == r_count);
    assign o_sts.hit    = !r_rd_c && (r_rd_a == r_rd_b);

    assign o_result = {{(OUT_DATA_W - 2){1'b0}}, r_ovf, r_equal};

endmodule

// ----- design/multiset_equality_check.sv -----
// Top level of the multiset equality block.
// Pairs of signed 32-bit values arrive one per cycle while the block is loading
// and are stored in order; the pair marked by tlast closes the run and starts
// the comparison. Up to MAX_ELEMENTS pairs are kept, later ones are dropped and
// reported through the overflow bit. The block first clears the claimed flags
// of the stored pairs, then for each element of the first set reads it and
// inspects the elements of the second set in turn (one memory read, one
// compare each), stopping at the first free match. The result is a mismatch as
// soon as an element of the first set finds no partner, equality once all have
// found one. No new pair is taken from the closing pair until the result has
// been taken.
module multiset_equality_check #(
    parameter int MAX_ELEMENTS = mec_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] value_a, [63:32] value_b
    input  logic [mec_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // last_pair
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] sets_equal, [1] overflow, [7:2] zero
    output logic [mec_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mec_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mec_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    mec_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_value_a (s_axis_tdata[VALUE_W-1:0]),
        .i_value_b (s_axis_tdata[2*VALUE_W-1:VALUE_W]),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_result  (m_axis_tdata)
    );

endmodule

// ----- design/mec_checker.sv -----
// Port-level checker of the multiset equality block and its binding.
`include "multiset_equality_check_macros.svh"

module mec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A result stays offered until it is taken.
    `MEC_ASSERT_ON(a_result_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped before it was taken")

    // No request is taken while a result is pending.
    `MEC_ASSERT_ON(a_no_overlap, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid, "request taken while a result is pending")

    // A closing request starts the comparison: input closed, no result yet.
    `MEC_ASSERT_ON(a_close_starts, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready && !m_axis_tvalid, "closing request did not start the comparison")

    // Padding bits of a result are zero.
    `MEC_ASSERT_ON(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0, "result padding not zero")

    // Reset leaves no result pending.
    `MEC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind multiset_equality_check mec_checker u_mec_checker (.*);

// ----- dv/multiset_result_checker.sv -----
// Checker that predicts and compares the verdicts of the multiset equality block.
module multiset_result_checker #(
    parameter int MAX_ELEMENTS = mec_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // [31:0] value_a, [63:32] value_b
    input  logic [mec_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // last_pair
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [0] sets_equal, [1] overflow, [7:2] zero
    input  logic [mec_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [mec_pkg::VALUE_W-1:0] value_t;

    typedef struct packed {
        logic sets_equal;
        logic overflow;
    } verdict_t;

    // Shadow copy of the two stored sets.
    value_t   first_vals [MAX_ELEMENTS];
    value_t   second_vals[MAX_ELEMENTS];
    int       stored_pairs;
    logic     pairs_dropped;
    verdict_t expected_verdicts[$];
    int       fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_verdicts.size();

    // Each element of the first set claims the first free equal element of the second.
    function automatic logic multisets_match(int n);
        logic [MAX_ELEMENTS-1:0] claimed;
        logic                    found;
        claimed = '0;
        for (int i = 0; i < n; i++) begin
            found = 1'b0;
            for (int j = 0; j < n; j++) begin
                if (!found && !claimed[j] && first_vals[i] == second_vals[j]) begin
                    claimed[j] = 1'b1;
                    found      = 1'b1;
                end
            end
            if (!found) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Track accepted pairs, predict each verdict and compare the results in order.
    always @(posedge i_clk) begin : track
        verdict_t want;
        if (!i_rst_n) begin
            stored_pairs  = 0;
            pairs_dropped = 1'b0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (stored_pairs < MAX_ELEMENTS) begin
                    first_vals[stored_pairs]  = i_s_tdata[31:0];
                    second_vals[stored_pairs] = i_s_tdata[63:32];
                    stored_pairs++;
                end else begin
                    pairs_dropped = 1'b1;
                end
                if (i_s_tlast) begin
                    want.sets_equal = multisets_match(stored_pairs);
                    want.overflow   = pairs_dropped;
                    expected_verdicts.push_back(want);
                    stored_pairs  = 0;
                    pairs_dropped = 1'b0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %b", $time,
                             i_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_m_tdata[0] !== want.sets_equal) begin
                        $display("%0t: sets_equal mismatch, expected %b, actual %b", $time,
                                 want.sets_equal, i_m_tdata[0]);
                        fail_count++;
                    end
                    if (i_m_tdata[1] !== want.overflow) begin
                        $display("%0t: overflow mismatch, expected %b, actual %b", $time,
                                 want.overflow, i_m_tdata[1]);
                        fail_count++;
                    end
                    if (i_m_tdata[7:2] !== 6'b0) begin
                        $display("%0t: padding mismatch, expected %b, actual %b", $time,
                                 6'b0, i_m_tdata[7:2]);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        fail_count    = 0;
        stored_pairs  = 0;
        pairs_dropped = 1'b0;
    end

endmodule

// ----- dv/tb_multiset_equality_check.sv -----
// Testbench top that drives streams of value pairs into the multiset equality block.
module tb_multiset_equality_check;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [mec_pkg::VALUE_W-1:0] value_t;

    localparam int     MAX_ELEMENTS = mec_pkg::MAX_ELEMENTS_DEF;
    localparam int     RESET_CYCLES = 8;
    localparam int     RANDOM_ITEMS = 1200;
    localparam int     MIN_STREAMS  = 40;
    localparam int     PHASE_ITEMS  = 150;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     DRAIN_CYCLES = 200;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam value_t VAL_MIN      = 32'sh8000_0000;
    localparam value_t VAL_MAX      = 32'sh7fff_ffff;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [31:0] value_a, [63:32] value_b
    logic [mec_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // last_pair
    logic                           s_axis_tlast  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [0] sets_equal, [1] overflow, [7:2] zero
    logic [mec_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int     fail_count;
    int     pending_results;
    int     cycle_count  = 0;
    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;
    logic   hold_toggle  = 1'b0;
    logic   hold_seen    = 1'b0;
    int     hold_left    = 0;
    value_t stream_a[$];
    value_t stream_b[$];

    multiset_equality_check #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    multiset_result_checker #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multiset_equality_check verification failed");
            $finish;
        end
    end

    // The result side: a long hold-off on request, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one pair, with random idle cycles beforehand, and wait for its request.
    task automatic send_pair(input value_t a, input value_t b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            s_axis_tlast  <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Send the queued stream with the final pair marked, then empty the queues.
    task automatic send_stream(inout int items);
        for (int k = 0; k < stream_a.size(); k++) begin
            send_pair(stream_a[k], stream_b[k], k == stream_a.size() - 1);
        end
        items += stream_a.size();
        stream_a.delete();
        stream_b.delete();
    endtask

    task automatic add_pair(input value_t a, input value_t b);
        stream_a.push_back(a);
        stream_b.push_back(b);
    endtask

    // Stop offering and wait until every outstanding verdict has been taken.
    task automatic wait_all_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    // Build a random stream: a permutation, a permutation with one changed element,
    // a draw from a tiny pool so that multiplicities clash, or pure noise.
    task automatic build_stream(input int len);
        int     kept;
        int     kind;
        int     idx;
        value_t pool[3];
        value_t swap_val;
        kept = (len > MAX_ELEMENTS) ? MAX_ELEMENTS : len;
        kind = $urandom_range(3);
        foreach (pool[p]) pool[p] = $urandom;
        for (int k = 0; k < kept; k++) begin
            stream_a.push_back((kind == 2) ? pool[$urandom_range(2)] : value_t'($urandom));
        end
        if (kind <= 1) begin
            stream_b = stream_a;
            for (int k = kept - 1; k > 0; k--) begin
                idx           = $urandom_range(k);
                swap_val      = stream_b[k];
                stream_b[k]   = stream_b[idx];
                stream_b[idx] = swap_val;
            end
            if (kind == 1) begin
                idx           = $urandom_range(kept - 1);
                stream_b[idx] = stream_b[idx] ^ (32'h1 << $urandom_range(31));
            end
        end else begin
            for (int k = 0; k < kept; k++) begin
                stream_b.push_back((kind == 2) ? pool[$urandom_range(2)] : value_t'($urandom));
            end
        end
        // Pairs beyond the capacity are dropped by the block.
        for (int k = kept; k < len; k++) begin
            add_pair($urandom, $urandom);
        end
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        int items_sent;
        int streams_sent;
        int phase;
        int len;
        items_sent   = 0;
        streams_sent = 0;
        phase        = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed streams: extreme values, permutations and multiplicity.
        add_pair(VAL_MIN, VAL_MIN);
        send_stream(items_sent);
        add_pair(VAL_MAX, VAL_MIN);
        send_stream(items_sent);
        add_pair(0, 0);
        send_stream(items_sent);
        add_pair(VAL_MAX, -1);
        add_pair(-1, VAL_MAX);
        send_stream(items_sent);
        add_pair(0, 1);
        add_pair(1, 0);
        send_stream(items_sent);
        add_pair(5, 5);
        add_pair(5, 7);
        add_pair(7, 5);
        send_stream(items_sent);
        // Same values but different multiplicity.
        add_pair(1, 1);
        add_pair(1, 2);
        add_pair(2, 2);
        send_stream(items_sent);
        // Two equal elements of the first set must not share one partner.
        add_pair(3, 3);
        add_pair(3, 4);
        send_stream(items_sent);
        add_pair(VAL_MIN, VAL_MAX);
        add_pair(VAL_MAX, VAL_MIN);
        add_pair(-1, -1);
        send_stream(items_sent);

        // Random streams in phases of different idling.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS || streams_sent < MIN_STREAMS) begin
            if (items_sent >= (phase + 1) * PHASE_ITEMS) begin
                phase++;
                wait_all_results();
                @(posedge i_clk);
                case (phase % 4)
                    0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
                    2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
                    default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
                endcase
                if (phase == 4) begin
                    hold_toggle = ~hold_toggle;
                end
            end
            // A full store, one dropped closing pair and a long overflow first.
            if (streams_sent == 0) begin
                len = MAX_ELEMENTS;
            end else if (streams_sent == 1) begin
                len = MAX_ELEMENTS + 1;
            end else if (streams_sent == 2) begin
                len = MAX_ELEMENTS + 6;
            end else if ($urandom_range(59) == 0) begin
                len = $urandom_range(MAX_ELEMENTS + 6, MAX_ELEMENTS - 4);
            end else if ($urandom_range(3) != 0) begin
                len = $urandom_range(8, 1);
            end else begin
                len = $urandom_range(24, 9);
            end
            build_stream(len);
            send_stream(items_sent);
            streams_sent++;
        end

        // Drain, then allow the block time to show any stray result.
        wait_all_results();
        @(posedge i_clk);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("multiset_equality_check verification clean");
        end else begin
            $display("multiset_equality_check verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/mec_pkg.sv
design/mec_ctrl.sv
design/mec_datapath.sv
design/multiset_equality_check.sv
design/mec_checker.sv
dv/multiset_result_checker.sv
dv/tb_multiset_equality_check.sv
